/* design/wpcs_pkg.sv */
package wpcs_pkg;

    localparam int PIX_W   = 8;
    localparam int FW_W    = 13;
    localparam int SUM_W   = 34;
    localparam int SPEED_W = 8;
    localparam int RATE_W  = 9;

    localparam logic [PIX_W-1:0]          PIX_FULL    = 8'hFF;
    localparam logic [FW_W-1:0]           WIDTH_RESET = 13'd640;
    localparam logic [SPEED_W-1:0]        SPEED_HALF  = 8'd128;
    localparam logic [SPEED_W-1:0]        SPEED_ZERO  = 8'd0;
    localparam logic signed [RATE_W-1:0]  RATE_LEFT   = 9'sd128;
    localparam logic signed [RATE_W-1:0]  RATE_RIGHT  = -9'sd128;
    localparam logic signed [RATE_W-1:0]  RATE_ZERO   = 9'sd0;

    // floor(x/3) = (x * DIV3_K) >> DIV3_SHIFT, exact for x < 2^19
    localparam int               DIV3_SHIFT = 20;
    localparam int               DIV3_W     = 19;
    localparam logic [DIV3_W-1:0] DIV3_K    = 19'd349526;

    typedef enum logic [1:0] {
        CMD_STOP    = 2'd0,
        CMD_LEFT    = 2'd1,
        CMD_FORWARD = 2'd2,
        CMD_RIGHT   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic white;
        logic last;
    } pix_tag_t;

    localparam int TAG_W = $bits(pix_tag_t);

endpackage

/* design/wpcs_if.sv */
interface wpcs_pix_if;
    logic                      valid;
    logic                      ready;
    logic [wpcs_pkg::PIX_W-1:0] red;
    logic [wpcs_pkg::PIX_W-1:0] green;
    logic [wpcs_pkg::PIX_W-1:0] blue;
    logic                      frame_end;

    modport source (output valid, red, green, blue, frame_end, input ready);
    modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

interface wpcs_cmd_if;
    logic                               valid;
    logic                               ready;
    wpcs_pkg::cmd_t                     command;
    logic [wpcs_pkg::SPEED_W-1:0]       linear_speed;
    logic signed [wpcs_pkg::RATE_W-1:0] angular_rate;

    modport source (output valid, command, linear_speed, angular_rate, input ready);
    modport sink   (input valid, command, linear_speed, angular_rate, output ready);
endinterface

interface wpcs_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [wpcs_pkg::FW_W-1:0] frame_width;

    modport source (output valid, frame_width, input ready);
    modport sink   (input valid, frame_width, output ready);
endinterface

/* design/wpcs_queue.sv */
module wpcs_queue #(
    parameter int DATA_W = 14,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW:0]       fill_reg;
    logic [AW:0]       fill_next;
    logic              push;
    logic              pop;

    assign push_ready = (fill_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (AW+1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/wpcs_front.sv */
module wpcs_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    wpcs_pix_if.sink                         pixel,
    wpcs_cfg_if.sink                         cfg,
    output logic                             push_valid,
    input  logic                             push_ready,
    output wpcs_pkg::pix_tag_t               push_tag,
    output logic [$clog2(MAX_WIDTH)-1:0]     push_col,
    output logic [$clog2(MAX_WIDTH)-1:0]     third_lo,
    output logic [$clog2(MAX_WIDTH)-1:0]     third_hi
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EFF_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (EFF_W > wpcs_pkg::FW_W) ? EFF_W : wpcs_pkg::FW_W;
    localparam int MUL_IN_W = EFF_W + 1;
    localparam int MUL_W  = MUL_IN_W + wpcs_pkg::DIV3_W;

    logic [wpcs_pkg::FW_W-1:0] width_reg;
    logic [COL_W-1:0]          col_reg;
    logic [COL_W-1:0]          col_next;
    logic [COL_W-1:0]          third_lo_reg;
    logic [COL_W-1:0]          third_hi_reg;
    logic [CMP_W-1:0]          width_ext;
    logic [EFF_W-1:0]          eff_width;
    logic [EFF_W-1:0]          col_inc;
    logic [MUL_W-1:0]          lo_prod;
    logic [MUL_W-1:0]          hi_prod;
    logic                      accept;

    assign cfg.ready   = 1'b1;
    assign pixel.ready = push_ready;
    assign push_valid  = pixel.valid;
    assign accept      = pixel.valid && push_ready;

    assign push_tag.white = (pixel.red   == wpcs_pkg::PIX_FULL) &&
                            (pixel.green == wpcs_pkg::PIX_FULL) &&
                            (pixel.blue  == wpcs_pkg::PIX_FULL);
    assign push_tag.last  = pixel.frame_end;
    assign push_col       = col_reg;
    assign third_lo       = third_lo_reg;
    assign third_hi       = third_hi_reg;

    // effective width clamped to 1..MAX_WIDTH
    assign width_ext = CMP_W'(width_reg);

    always_comb
    begin
        if (width_ext == '0)
        begin
            eff_width = EFF_W'(1);
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            eff_width = EFF_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = EFF_W'(width_ext);
        end
    end

    assign col_inc = EFF_W'(col_reg) + EFF_W'(1);

    always_comb
    begin
        col_next = col_reg;
        if (accept)
        begin
            if (pixel.frame_end || (col_inc >= eff_width))
            begin
                col_next = '0;
            end
            else
            begin
                col_next = COL_W'(col_inc);
            end
        end
    end

    assign lo_prod = MUL_W'(eff_width) * MUL_W'(wpcs_pkg::DIV3_K);
    assign hi_prod = MUL_W'({eff_width, 1'b0}) * MUL_W'(wpcs_pkg::DIV3_K);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= wpcs_pkg::WIDTH_RESET;
            col_reg   <= '0;
        end
        else
        begin
            col_reg <= col_next;
            if (cfg.valid)
            begin
                width_reg <= cfg.frame_width;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        third_lo_reg <= COL_W'(lo_prod >> wpcs_pkg::DIV3_SHIFT);
        third_hi_reg <= COL_W'(hi_prod >> wpcs_pkg::DIV3_SHIFT);
    end

endmodule

/* design/wpcs_back.sv */
module wpcs_back #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_PIXELS = 4194304
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  wpcs_pkg::pix_tag_t           pop_tag,
    input  logic [$clog2(MAX_WIDTH)-1:0] pop_col,
    input  logic [$clog2(MAX_WIDTH)-1:0] third_lo,
    input  logic [$clog2(MAX_WIDTH)-1:0] third_hi,
    wpcs_cmd_if.source                   steer
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CNT_W  = $clog2(2 * MAX_PIXELS);
    localparam int SUM_W  = wpcs_pkg::SUM_W;
    localparam int PROD_W = CNT_W + COL_W;
    localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

    logic [SUM_W-1:0]  acc_sum_reg;
    logic [CNT_W-1:0]  acc_cnt_reg;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_new;
    logic [CNT_W-1:0]  cnt_new;

    logic              s1_valid_reg;
    logic [SUM_W-1:0]  s1_sum_reg;
    logic [CNT_W-1:0]  s1_cnt_reg;

    logic              s2_valid_reg;
    logic [SUM_W-1:0]  s2_sum_reg;
    logic              s2_zero_reg;
    logic [PROD_W-1:0] s2_lo_reg;
    logic [PROD_W-1:0] s2_hi_reg;

    logic                               out_valid_reg;
    wpcs_pkg::cmd_t                     out_cmd_reg;
    logic [wpcs_pkg::SPEED_W-1:0]       out_speed_reg;
    logic signed [wpcs_pkg::RATE_W-1:0] out_rate_reg;
    wpcs_pkg::cmd_t                     out_cmd_next;

    logic out_free;
    logic s2_free;
    logic s1_free;
    logic pop;

    assign out_free  = !out_valid_reg || steer.ready;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign pop_ready = !pop_tag.last || s1_free;
    assign pop       = pop_valid && pop_ready;

    assign sum_add = (SUM_W+1)'(acc_sum_reg) + (SUM_W+1)'(pop_col);

    always_comb
    begin
        sum_new = acc_sum_reg;
        cnt_new = acc_cnt_reg;
        if (pop_tag.white)
        begin
            sum_new = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            if (!(&acc_cnt_reg))
            begin
                cnt_new = acc_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        if (s2_zero_reg)
        begin
            out_cmd_next = wpcs_pkg::CMD_STOP;
        end
        else if (CMP_W'(s2_sum_reg) < CMP_W'(s2_lo_reg))
        begin
            out_cmd_next = wpcs_pkg::CMD_LEFT;
        end
        else if (CMP_W'(s2_sum_reg) < CMP_W'(s2_hi_reg))
        begin
            out_cmd_next = wpcs_pkg::CMD_FORWARD;
        end
        else
        begin
            out_cmd_next = wpcs_pkg::CMD_RIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_sum_reg   <= '0;
            acc_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                acc_sum_reg <= pop_tag.last ? '0 : sum_new;
                acc_cnt_reg <= pop_tag.last ? '0 : cnt_new;
            end
            if (s1_free)
            begin
                s1_valid_reg <= pop && pop_tag.last;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && pop && pop_tag.last)
        begin
            s1_sum_reg <= sum_new;
            s1_cnt_reg <= cnt_new;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_sum_reg  <= s1_sum_reg;
            s2_zero_reg <= (s1_cnt_reg == '0);
            s2_lo_reg   <= PROD_W'(s1_cnt_reg) * PROD_W'(third_lo);
            s2_hi_reg   <= PROD_W'(s1_cnt_reg) * PROD_W'(third_hi);
        end
        if (out_free && s2_valid_reg)
        begin
            out_cmd_reg   <= out_cmd_next;
            out_speed_reg <= (out_cmd_next == wpcs_pkg::CMD_FORWARD) ?
                             wpcs_pkg::SPEED_HALF : wpcs_pkg::SPEED_ZERO;
            unique case (out_cmd_next)
                wpcs_pkg::CMD_LEFT:  out_rate_reg <= wpcs_pkg::RATE_LEFT;
                wpcs_pkg::CMD_RIGHT: out_rate_reg <= wpcs_pkg::RATE_RIGHT;
                default:             out_rate_reg <= wpcs_pkg::RATE_ZERO;
            endcase
        end
    end

    assign steer.valid        = out_valid_reg;
    assign steer.command      = out_cmd_reg;
    assign steer.linear_speed = out_speed_reg;
    assign steer.angular_rate = out_rate_reg;

endmodule

/* design/white_pixel_centroid_steer_top.sv */
// Channel  Dir  Payload                                   Transaction
// pixel    in   red, green, blue, frame_end               valid & ready
// cfg      in   frame_width                               valid & ready (ready held high)
// steer    out  command, linear_speed, angular_rate       valid & ready
//
// One pixel per cycle sustained unless steer back-pressure holds a frame end; the column
// counter and accumulators each advance per taken pixel. After its last pixel a command passes
// three registered steps: dequeue and accumulate, multiply, compare.
// Frame-end transactions pass the three-stage command pipeline; it and the queue absorb stalls.
// rst_n clears counter, accumulators and valids at once; frame_width returns to 640.
module white_pixel_centroid_steer_top #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_PIXELS  = 4194304,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    wpcs_pix_if.sink   pixel,
    wpcs_cfg_if.sink   cfg,
    wpcs_cmd_if.source steer
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int DATA_W = wpcs_pkg::TAG_W + COL_W;

    logic               push_valid;
    logic               push_ready;
    wpcs_pkg::pix_tag_t push_tag;
    logic [COL_W-1:0]   push_col;
    logic               pop_valid;
    logic               pop_ready;
    logic [DATA_W-1:0]  pop_data;
    logic [COL_W-1:0]   third_lo;
    logic [COL_W-1:0]   third_hi;

    wpcs_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tag   (push_tag),
        .push_col   (push_col),
        .third_lo   (third_lo),
        .third_hi   (third_hi)
    );

    wpcs_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_tag, push_col}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    wpcs_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_tag   (wpcs_pkg::pix_tag_t'(pop_data[DATA_W-1:COL_W])),
        .pop_col   (pop_data[COL_W-1:0]),
        .third_lo  (third_lo),
        .third_hi  (third_hi),
        .steer     (steer)
    );

endmodule

/* design/wpcs_checker.sv */
module wpcs_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               pix_valid,
    input logic                               pix_ready,
    input logic                               pix_frame_end,
    input logic                               out_valid,
    input logic                               out_ready,
    input wpcs_pkg::cmd_t                     out_command,
    input logic [wpcs_pkg::SPEED_W-1:0]       out_speed,
    input logic signed [wpcs_pkg::RATE_W-1:0] out_rate
);

    // frame ends taken but not yet answered
    logic [7:0] pend_reg;
    logic [7:0] pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if (pix_valid && pix_ready && pix_frame_end)
        begin
            pend_next = pend_next + 8'd1;
        end
        if (out_valid && out_ready)
        begin
            pend_next = pend_next - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("steer transaction dropped while stalled");

    a_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_command == wpcs_pkg::CMD_FORWARD) ?
                       (out_speed == wpcs_pkg::SPEED_HALF) :
                       (out_speed == wpcs_pkg::SPEED_ZERO)))
        else $error("linear speed does not match command");

    a_rate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_command == wpcs_pkg::CMD_LEFT) ?
                       (out_rate == wpcs_pkg::RATE_LEFT) :
                       ((out_command == wpcs_pkg::CMD_RIGHT) ?
                        (out_rate == wpcs_pkg::RATE_RIGHT) :
                        (out_rate == wpcs_pkg::RATE_ZERO))))
        else $error("angular rate does not match command");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 8'd0))
        else $error("steer transaction without a pending frame end");

endmodule

bind white_pixel_centroid_steer_top wpcs_checker u_wpcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pix_valid     (pixel.valid),
    .pix_ready     (pixel.ready),
    .pix_frame_end (pixel.frame_end),
    .out_valid     (steer.valid),
    .out_ready     (steer.ready),
    .out_command   (steer.command),
    .out_speed     (steer.linear_speed),
    .out_rate      (steer.angular_rate)
);
